// File: design/lzw_decoder_macros.svh
// Assertion macros used by the LZW decoder top level.
`ifndef LZW_DECODER_MACROS_SVH
`define LZW_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define LZWD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define LZWD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LZWD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define LZWD_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: design/lzwd_pkg.sv
// Shared constants, controller states and command/status types of the LZW decoder.
`default_nettype none
package lzwd_pkg;

   // Fixed field widths.
   localparam int CODE_W      = 12;
   localparam int BYTE_W      = 8;
   localparam int REQ_TDATA_W = 16;
   localparam int ROOTS       = 256;

   // Default sizes of the dictionary and of the longest string.
   localparam int DICT_SIZE_DEF = 4096;
   localparam int MAX_LEN_DEF   = 64;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_SETTLE,
      ST_EMIT,
      ST_EXTRA,
      ST_ERR
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic step;
      logic commit;
      logic pop;
      logic emit_first;
      logic emit_bad;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_bad;
      logic cur_root;
      logic stack_one;
      logic stack_empty;
      logic stack_full;
      logic special;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// File: design/lzwd_ctrl.sv
// Controller state machine of the LZW decoder.
`default_nettype none
module lzwd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire lzwd_pkg::sts_type sts,
   output lzwd_pkg::cmd_type     cmd
);
   import lzwd_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = sts.req_bad ? ST_ERR : ST_WALK;
            end
         end
         ST_WALK: begin
            // One chain link per cycle until a root byte is reached.
            cmd.step = 1'b1;
            if (sts.cur_root) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            cmd.commit = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.pop = 1'b1;
               if (sts.stack_one) begin
                  state_in = sts.special ? ST_EXTRA : ST_IDLE;
               end
            end
         end
         ST_EXTRA: begin
            if (sts.out_free) begin
               cmd.emit_first = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (sts.out_free) begin
               cmd.emit_bad = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: design/lzwd_datapath.sv
// Datapath of the LZW decoder: dictionary, byte stack, stream state and result register.
`default_nettype none
module lzwd_datapath #(
   parameter int DICT_SIZE = lzwd_pkg::DICT_SIZE_DEF,
   parameter int MAX_LEN   = lzwd_pkg::MAX_LEN_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lzwd_pkg::cmd_type                 cmd,
   output lzwd_pkg::sts_type                      sts,
   input  wire logic [lzwd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [lzwd_pkg::BYTE_W-1:0]            rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tuser
);
   import lzwd_pkg::*;

   localparam int AW    = $clog2(DICT_SIZE);
   localparam int NFW   = $clog2(DICT_SIZE + 1);
   localparam int CMP_W = (NFW > CODE_W) ? NFW : CODE_W;
   localparam int SAW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LW    = $clog2(MAX_LEN + 1);

   // Dictionary and byte stack.
   logic [CODE_W-1:0] prefix_mem [DICT_SIZE];
   logic [BYTE_W-1:0] suffix_mem [DICT_SIZE];
   logic [BYTE_W-1:0] stack_mem  [MAX_LEN];

   // Stream state.
   logic [NFW-1:0]    nf_ff, nf_in;
   logic [CODE_W-1:0] prev_ff, prev_in;
   logic              hp_ff, hp_in;
   logic [LW-1:0]     plen_ff, plen_in;

   // Per-word state.
   logic [CODE_W-1:0] cur_ff, cur_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              special_ff, special_in;
   logic              add_ff, add_in;
   logic [BYTE_W-1:0] first_ff, first_in;
   logic [LW-1:0]     sp_ff, sp_in;

   // Registered memory reads.
   logic [CODE_W-1:0] rd_prefix_ff;
   logic [BYTE_W-1:0] rd_suffix_ff;
   logic [BYTE_W-1:0] st_rd_ff;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic [CODE_W-1:0] code;
   logic [NFW-1:0]    nf_eff;
   logic              hp_eff;
   logic [LW-1:0]     plen_eff;
   logic              ok_add;
   logic [CMP_W-1:0]  code_x;
   logic [CMP_W-1:0]  nf_x;
   logic              is_special;
   logic              req_bad;
   logic              cur_root;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] push_byte;
   logic [LW-1:0]     sp_dec;
   logic [SAW-1:0]    st_addr;
   logic              out_free;
   logic              load;

   // Checks on the incoming word, with a stream restart applied first.
   always_comb begin
      code       = req_tdata[CODE_W-1:0];
      nf_eff     = req_tuser ? NFW'(ROOTS) : nf_ff;
      hp_eff     = !req_tuser && hp_ff;
      plen_eff   = hp_eff ? plen_ff : '0;
      ok_add     = hp_eff && (nf_eff < NFW'(DICT_SIZE)) && (plen_eff < LW'(MAX_LEN));
      code_x     = CMP_W'(code);
      nf_x       = CMP_W'(nf_eff);
      is_special = (code_x == nf_x);
      req_bad    = (code_x >= CMP_W'(DICT_SIZE)) || (code_x > nf_x) ||
                   (is_special && !ok_add);
   end

   // Chain walk: the dictionary is addressed with the next current code.
   always_comb begin
      cur_root  = (cur_ff < CODE_W'(ROOTS));
      push_byte = cur_root ? cur_ff[BYTE_W-1:0] : rd_suffix_ff;
      priority if (cmd.accept) begin
         cur_in = is_special ? prev_ff : code;
      end else if (cmd.step && !cur_root) begin
         cur_in = rd_prefix_ff;
      end else begin
         cur_in = cur_ff;
      end
      rd_addr = AW'(cur_in);
   end

   // Stack pointer; the read port always fetches the next top of stack.
   always_comb begin
      priority if (cmd.accept) begin
         sp_in = '0;
      end else if (cmd.step) begin
         sp_in = sp_ff + LW'(1);
      end else if (cmd.pop) begin
         sp_in = sp_ff - LW'(1);
      end else begin
         sp_in = sp_ff;
      end
      sp_dec  = sp_in - LW'(1);
      st_addr = sp_dec[SAW-1:0];
   end

   // Per-word and stream state updates.
   always_comb begin
      code_in    = cmd.accept ? code : code_ff;
      special_in = cmd.accept ? is_special : special_ff;
      add_in     = cmd.accept ? ok_add : add_ff;
      first_in   = (cmd.step && cur_root) ? cur_ff[BYTE_W-1:0] : first_ff;
      nf_in      = nf_ff;
      hp_in      = hp_ff;
      prev_in    = prev_ff;
      plen_in    = plen_ff;
      if (cmd.accept) begin
         nf_in = nf_eff;
         hp_in = hp_eff;
      end
      if (cmd.commit) begin
         // The decoded word becomes the previous one; its string length is kept.
         hp_in   = 1'b1;
         prev_in = code_ff;
         plen_in = special_ff ? sp_ff + LW'(1) : sp_ff;
         if (add_ff) begin
            nf_in = nf_ff + NFW'(1);
         end
      end
   end

   // Result register loads.
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      load         = cmd.pop || cmd.emit_first || cmd.emit_bad;
      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      priority if (cmd.pop) begin
         rsp_byte_in = st_rd_ff;
         rsp_last_in = (sp_ff == LW'(1)) && !special_ff;
         rsp_bad_in  = 1'b0;
      end else if (cmd.emit_first) begin
         rsp_byte_in = first_ff;
         rsp_last_in = 1'b1;
         rsp_bad_in  = 1'b0;
      end else if (cmd.emit_bad) begin
         rsp_byte_in = '0;
         rsp_last_in = 1'b1;
         rsp_bad_in  = 1'b1;
      end else begin
         rsp_byte_in = rsp_byte_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         nf_ff        <= NFW'(ROOTS);
         prev_ff      <= '0;
         hp_ff        <= 1'b0;
         plen_ff      <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nf_ff        <= nf_in;
         prev_ff      <= prev_in;
         hp_ff        <= hp_in;
         plen_ff      <= plen_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      code_ff     <= code_in;
      special_ff  <= special_in;
      add_ff      <= add_in;
      first_ff    <= first_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // Dictionary: one write for a learned entry, one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.commit && add_ff) begin
         prefix_mem[nf_ff[AW-1:0]] <= prev_ff;
         suffix_mem[nf_ff[AW-1:0]] <= first_ff;
      end
      rd_prefix_ff <= prefix_mem[rd_addr];
      rd_suffix_ff <= suffix_mem[rd_addr];
   end

   // Byte stack: bytes are pushed last first and popped in string order.
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         stack_mem[sp_ff[SAW-1:0]] <= push_byte;
      end
      st_rd_ff <= stack_mem[st_addr];
   end

   // Status to the controller.
   always_comb begin
      sts.req_bad     = req_bad;
      sts.cur_root    = cur_root;
      sts.stack_one   = (sp_ff == LW'(1));
      sts.stack_empty = (sp_ff == '0);
      sts.stack_full  = (sp_ff == LW'(MAX_LEN));
      sts.special     = special_ff;
      sts.out_free    = out_free;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

endmodule
`default_nettype wire

// File: design/lzw_decoder.sv
// Top level of the LZW decoder: controller, datapath and checks.
// One code word goes in, the bytes of its string come out first byte first, the
// final byte marked with tlast; a code beyond the next free dictionary entry, or
// equal to it when no entry can be added, gives a single word with tuser set and
// the dictionary untouched. A word is handled in order: the code is taken, the
// prefix chain is walked down (one registered dictionary read per link), the new
// entry, if any, is stored, and the byte stack gives one byte per cycle through
// the result register while rsp_tready takes each byte. When the code names the
// entry being built, only the previous string, one byte shorter, is walked and
// its first byte is replayed from a register. A full result register that waits
// for rsp_tready stalls the byte output. The dictionary needs no clearing
// after reset; a tuser flag on an input word restarts the stream at the 256 roots.
`default_nettype none
`include "lzw_decoder_macros.svh"
module lzw_decoder #(
   parameter int DICT_SIZE = lzwd_pkg::DICT_SIZE_DEF,
   parameter int MAX_LEN   = lzwd_pkg::MAX_LEN_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // Bits 11:0 code, bits 15:12 zero.
   input  wire logic [lzwd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // Bit 0 start_req.
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // Bits 7:0 out_byte.
   output logic [lzwd_pkg::BYTE_W-1:0]            rsp_tdata,
   output logic                                   rsp_tlast,
   // Bit 0 bad_code.
   output logic                                   rsp_tuser
);
   import lzwd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencing of each code word.
   lzwd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Dictionary, stack and result register.
   lzwd_datapath #(
      .DICT_SIZE (DICT_SIZE),
      .MAX_LEN   (MAX_LEN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // A bad-code word always closes its code.
   `LZWD_ASSERT_IMP(a_bad_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "bad not last")
   // The stack is never popped empty.
   `LZWD_ASSERT_IMP(a_pop_nonempty, clock, reset, cmd.pop, !sts.stack_empty, "empty pop")
   // A chain walk never runs past the longest string.
   `LZWD_ASSERT_IMP(a_push_room, clock, reset, cmd.step, !sts.stack_full, "stack overflow")
   // One code word at a time.
   `LZWD_ASSERT_NXT(a_one_word, clock, reset, req_tvalid && req_tready, !req_tready, "busy accept")

endmodule
`default_nettype wire
